FILE: hdl/ishc_pkg.sv
// Shared constants, types and helpers for the interleaved SECDED codec.
// Used by the codec and the column accumulator; depends on nothing.
`default_nettype none

package ishc_pkg;

    localparam int WINDOW_WORDS = 16;
    localparam int WORD_BITS    = 16;

    // Width of the word fields on the ports.
    localparam int FIELD_W = 16;
    // Columns that can carry a one: bits of the port field above these are always zero.
    localparam int COL_W   = (WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W;
    localparam int POS_W   = $clog2(WINDOW_WORDS);
    localparam int CNT_W   = $clog2(WINDOW_WORDS + 1);
    localparam int OUT_W   = 3 * FIELD_W;

    // Positions 0, 1 and 2 carry parity, so data always starts at 3.
    localparam logic [POS_W-1:0] FIRST_DATA_POS = POS_W'(3);

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } t_mode;

    typedef struct packed {
        logic                 clr;
        logic                 absorb;
        logic [POS_W-1:0]     pos;
        logic [COL_W-1:0]     word;
    } t_acc_ctl;

    typedef struct packed {
        logic [COL_W-1:0][POS_W-1:0] syn;
        logic [COL_W-1:0]            par;
    } t_col_state;

    // Next data position after p: step once, skip a single parity position.
    function automatic logic [CNT_W-1:0] next_data_pos(input logic [POS_W-1:0] p);
        logic [CNT_W-1:0] n;
        n = CNT_W'(p) + 1'b1;
        if ((n & (n - 1'b1)) == '0) begin
            n = n + 1'b1;
        end
        return n;
    endfunction

    function automatic logic in_window(input logic [POS_W-1:0] s);
        return CNT_W'(s) < CNT_W'(WINDOW_WORDS);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/interleaved_secded_hamming_codec.sv
// The first output beat is valid in S_EMIT, after S_PRIME, once a beat completes a window.
// Throughput: one input beat per cycle while loading (11 data words to encode, 16 to decode),
// the S_PRIME state for the first store read, then one output beat per cycle while
// m_axis_tready is high (16 coded words, or 11 data words); the store's single read port sets this.
// Reset: mode encode, empty window, syndromes and parity cleared; the store is not cleared.
`default_nettype none

module interleaved_secded_hamming_codec (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic                         i_cfg_wr_data,   // mode
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [ishc_pkg::FIELD_W-1:0] s_axis_tdata,    // word
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // word_res [15:0], corrected_columns [31:16], uncorrectable_columns [47:32]
    output logic      [ishc_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast     // last
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_PRIME,
        S_EMIT
    } t_state;

    t_state                       r_state;
    ishc_pkg::t_mode              r_mode;
    logic [ishc_pkg::POS_W-1:0]   r_pos;

    logic                         w_in_fire;
    logic                         w_out_fire;
    logic [ishc_pkg::CNT_W-1:0]   w_load_next;
    logic [ishc_pkg::CNT_W-1:0]   w_emit_next;
    logic                         w_emit_last;
    logic [ishc_pkg::POS_W-1:0]   w_rd_addr;
    logic [ishc_pkg::COL_W-1:0]   w_rd_data;
    logic [ishc_pkg::POS_W-1:0]   w_load_start;
    ishc_pkg::t_acc_ctl           w_acc_ctl;
    ishc_pkg::t_col_state         w_cols;
    logic [ishc_pkg::COL_W-1:0]   w_word;
    logic [ishc_pkg::COL_W-1:0]   w_corr;
    logic [ishc_pkg::COL_W-1:0]   w_unc;
    logic [ishc_pkg::FIELD_W-1:0] w_word_x;
    logic [ishc_pkg::FIELD_W-1:0] w_corr_x;
    logic [ishc_pkg::FIELD_W-1:0] w_unc_x;

    assign s_axis_tready = (r_state == S_LOAD);
    assign m_axis_tvalid = (r_state == S_EMIT);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_fire    = m_axis_tvalid && m_axis_tready;

    assign w_load_start = (r_mode == ishc_pkg::MODE_ENCODE) ?
                          ishc_pkg::FIRST_DATA_POS : '0;

    always_comb begin
        if (r_mode == ishc_pkg::MODE_ENCODE) begin
            w_load_next = ishc_pkg::next_data_pos(r_pos);
            w_emit_next = ishc_pkg::CNT_W'(r_pos) + 1'b1;
        end else begin
            w_load_next = ishc_pkg::CNT_W'(r_pos) + 1'b1;
            w_emit_next = ishc_pkg::next_data_pos(r_pos);
        end
        w_emit_last = (w_emit_next >= ishc_pkg::CNT_W'(ishc_pkg::WINDOW_WORDS));
    end

    // Prefetch the next entry on an output beat so the read data stays aligned.
    assign w_rd_addr = w_out_fire ? w_emit_next[ishc_pkg::POS_W-1:0] : r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_mode  <= ishc_pkg::MODE_ENCODE;
            r_pos   <= ishc_pkg::FIRST_DATA_POS;
        end else if (i_cfg_wr_en) begin
            r_state <= S_LOAD;
            r_mode  <= ishc_pkg::t_mode'(i_cfg_wr_data);
            r_pos   <= (ishc_pkg::t_mode'(i_cfg_wr_data) == ishc_pkg::MODE_ENCODE) ?
                       ishc_pkg::FIRST_DATA_POS : '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_fire) begin
                        if (w_load_next >= ishc_pkg::CNT_W'(ishc_pkg::WINDOW_WORDS)) begin
                            r_state <= S_PRIME;
                            r_pos   <= (r_mode == ishc_pkg::MODE_ENCODE) ?
                                       '0 : ishc_pkg::FIRST_DATA_POS;
                        end else begin
                            r_pos <= w_load_next[ishc_pkg::POS_W-1:0];
                        end
                    end
                end
                S_PRIME: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_fire) begin
                        if (w_emit_last) begin
                            r_state <= S_LOAD;
                            r_pos   <= w_load_start;
                        end else begin
                            r_pos <= w_emit_next[ishc_pkg::POS_W-1:0];
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    always_comb begin
        w_acc_ctl.clr    = i_cfg_wr_en || (w_out_fire && w_emit_last);
        w_acc_ctl.absorb = w_in_fire;
        w_acc_ctl.pos    = r_pos;
        w_acc_ctl.word   = s_axis_tdata[ishc_pkg::COL_W-1:0];
    end

    ishc_col_acc u_col_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_acc_ctl),
        .o_state (w_cols)
    );

    ishc_ram #(
        .DEPTH (ishc_pkg::WINDOW_WORDS),
        .WIDTH (ishc_pkg::COL_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_in_fire),
        .i_wr_addr (r_pos),
        .i_wr_data (s_axis_tdata[ishc_pkg::COL_W-1:0]),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Build the word at r_pos from the store and the column state.
    always_comb begin
        w_word = w_rd_data;
        w_corr = '0;
        w_unc  = '0;
        if (r_mode == ishc_pkg::MODE_ENCODE) begin
            for (int c = 0; c < ishc_pkg::COL_W; c++) begin
                if (r_pos == '0) begin
                    w_word[c] = w_cols.par[c] ^ (^w_cols.syn[c]);
                end else if ((r_pos & (r_pos - 1'b1)) == '0) begin
                    w_word[c] = |(w_cols.syn[c] & r_pos);
                end
            end
        end else begin
            for (int c = 0; c < ishc_pkg::COL_W; c++) begin
                if (w_cols.par[c]) begin
                    w_corr[c] = ishc_pkg::in_window(w_cols.syn[c]);
                    w_unc[c]  = !ishc_pkg::in_window(w_cols.syn[c]);
                    // flip the single bit in error at this position
                    w_word[c] = w_rd_data[c] ^ (w_cols.syn[c] == r_pos);
                end else begin
                    w_unc[c] = (w_cols.syn[c] != '0);
                end
            end
        end
    end

    always_comb begin
        w_word_x = '0;
        w_corr_x = '0;
        w_unc_x  = '0;
        w_word_x[ishc_pkg::COL_W-1:0] = w_word;
        w_corr_x[ishc_pkg::COL_W-1:0] = w_corr;
        w_unc_x[ishc_pkg::COL_W-1:0]  = w_unc;
    end

    assign m_axis_tdata = {w_unc_x, w_corr_x, w_word_x};
    assign m_axis_tlast = w_emit_last;

    a_no_load_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_in_fire && m_axis_tvalid))
        else $error("input beat accepted while window is being emitted");

    a_load_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && m_axis_tlast && !i_cfg_wr_en) |=> (s_axis_tready && !m_axis_tvalid))
        else $error("block did not return to loading after last beat");

    a_flags_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((w_corr & w_unc) == '0))
        else $error("column flagged both corrected and uncorrectable");

    a_encode_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_mode == ishc_pkg::MODE_ENCODE) |->
        (m_axis_tdata[ishc_pkg::OUT_W-1:ishc_pkg::FIELD_W] == '0))
        else $error("status flags set in encode mode");

endmodule

`default_nettype wire

FILE: hdl/ishc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module ishc_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: hdl/ishc_col_acc.sv
// Per-column syndrome and overall parity accumulators for one window.
// Depends on ishc_pkg.
`default_nettype none

module ishc_col_acc (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire ishc_pkg::t_acc_ctl    i_ctl,
    output ishc_pkg::t_col_state       o_state
);

    ishc_pkg::t_col_state r_state;
    ishc_pkg::t_col_state n_state;

    always_comb begin
        n_state = r_state;
        if (i_ctl.clr) begin
            n_state = '0;
        end else if (i_ctl.absorb) begin
            n_state.par = r_state.par ^ i_ctl.word;
            for (int c = 0; c < ishc_pkg::COL_W; c++) begin
                if (i_ctl.word[c]) begin
                    n_state.syn[c] = r_state.syn[c] ^ i_ctl.pos;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for interleaved_secded_hamming_codec: encodes and decodes windows
// and compares every output beat with a predictor kept in a scoreboard class.
// Depends on ishc_pkg and the codec RTL only.

module tb;

    localparam int DATA_WORDS  = 11;   // 16 positions minus 0, 1, 2, 4 and 8
    localparam int STALL_LIMIT = 4000;
    localparam int TARGET_WORDS = 370;

    typedef struct {
        logic [ishc_pkg::FIELD_W-1:0] word;
        logic                         is_last;
        logic [ishc_pkg::FIELD_W-1:0] corr;
        logic [ishc_pkg::FIELD_W-1:0] unc;
    } t_codec_beat;

    class codec_scoreboard;
        ishc_pkg::t_mode              mode;
        logic [ishc_pkg::FIELD_W-1:0] store [ishc_pkg::WINDOW_WORDS];
        int unsigned                  load_pos;
        int unsigned                  syndrome [ishc_pkg::FIELD_W];
        logic [ishc_pkg::FIELD_W-1:0] parity;
        t_codec_beat                  awaited [$];
        int                           errors;

        function new();
            mode   = ishc_pkg::MODE_ENCODE;
            errors = 0;
            clear_window();
        endfunction

        static function bit is_check_pos(int unsigned p);
            return p == 0 || (p & (p - 1)) == 0;
        endfunction

        function int unsigned skip_checks(int unsigned p);
            while (p < ishc_pkg::WINDOW_WORDS && is_check_pos(p)) p++;
            return p;
        endfunction

        function void clear_window();
            load_pos = 0;
            parity   = '0;
            foreach (syndrome[c]) syndrome[c] = 0;
        endfunction

        function void set_mode(ishc_pkg::t_mode m);
            mode = m;
            clear_window();
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void absorb(int unsigned p, logic [ishc_pkg::FIELD_W-1:0] w);
            store[p] = w;
            parity ^= w;
            for (int c = 0; c < ishc_pkg::COL_W; c++) begin
                if (w[c]) syndrome[c] ^= p;
            end
        endfunction

        function void push_encoded();
            logic [ishc_pkg::FIELD_W-1:0] sum;
            t_codec_beat                  b;
            for (int unsigned q = 1; q < ishc_pkg::WINDOW_WORDS; q = q * 2) begin
                store[q] = '0;
                for (int c = 0; c < ishc_pkg::COL_W; c++) store[q][c] = (syndrome[c] & q) != 0;
            end
            sum = '0;
            for (int p = 1; p < ishc_pkg::WINDOW_WORDS; p++) sum ^= store[p];
            store[0] = sum;
            for (int p = 0; p < ishc_pkg::WINDOW_WORDS; p++) begin
                b.word    = store[p];
                b.is_last = (p == ishc_pkg::WINDOW_WORDS - 1);
                b.corr    = '0;
                b.unc     = '0;
                awaited.insert(awaited.size(), b);
            end
        endfunction

        function void push_decoded();
            logic [ishc_pkg::FIELD_W-1:0] corr;
            logic [ishc_pkg::FIELD_W-1:0] unc;
            int unsigned                  last_data;
            t_codec_beat                  b;
            corr = '0;
            unc  = '0;
            for (int c = 0; c < ishc_pkg::COL_W; c++) begin
                if (parity[c]) begin
                    // odd parity: single error, syndrome zero means the overall parity bit
                    if (syndrome[c] < ishc_pkg::WINDOW_WORDS) begin
                        store[syndrome[c]][c] = ~store[syndrome[c]][c];
                        corr[c] = 1'b1;
                    end else begin
                        unc[c] = 1'b1;
                    end
                end else if (syndrome[c] != 0) begin
                    unc[c] = 1'b1;
                end
            end
            last_data = 0;
            for (int p = 0; p < ishc_pkg::WINDOW_WORDS; p++) begin
                if (!is_check_pos(p)) last_data = p;
            end
            for (int p = 0; p < ishc_pkg::WINDOW_WORDS; p++) begin
                if (!is_check_pos(p)) begin
                    b.word    = store[p];
                    b.is_last = (p == last_data);
                    b.corr    = corr;
                    b.unc     = unc;
                    awaited.insert(awaited.size(), b);
                end
            end
        endfunction

        function void note_word(logic [ishc_pkg::FIELD_W-1:0] w);
            int unsigned p;
            if (mode == ishc_pkg::MODE_ENCODE) begin
                p = skip_checks(load_pos);
                if (p >= ishc_pkg::WINDOW_WORDS) p = skip_checks(0);
                absorb(p, w);
                load_pos = skip_checks(p + 1);
                if (load_pos >= ishc_pkg::WINDOW_WORDS) begin
                    push_encoded();
                    clear_window();
                end
            end else begin
                p = (load_pos >= ishc_pkg::WINDOW_WORDS) ? 0 : load_pos;
                absorb(p, w);
                load_pos = p + 1;
                if (load_pos >= ishc_pkg::WINDOW_WORDS) begin
                    push_decoded();
                    clear_window();
                end
            end
        endfunction

        function void check_beat(logic [ishc_pkg::FIELD_W-1:0] word, logic is_last,
                                 logic [ishc_pkg::FIELD_W-1:0] corr,
                                 logic [ishc_pkg::FIELD_W-1:0] unc);
            t_codec_beat b;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, word_res %h last %b corr %h unc %h",
                         $time, word, is_last, corr, unc);
                return;
            end
            b = awaited.pop_front();
            if (b.word !== word) begin
                errors++;
                $display("%0t: word_res expected %h, got %h", $time, b.word, word);
            end
            if (b.is_last !== is_last) begin
                errors++;
                $display("%0t: last expected %b, got %b", $time, b.is_last, is_last);
            end
            if (b.corr !== corr) begin
                errors++;
                $display("%0t: corrected_columns expected %h, got %h", $time, b.corr, corr);
            end
            if (b.unc !== unc) begin
                errors++;
                $display("%0t: uncorrectable_columns expected %h, got %h", $time, b.unc, unc);
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_wr_en;
    logic                           i_cfg_wr_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [ishc_pkg::FIELD_W-1:0]   s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [ishc_pkg::OUT_W-1:0]     m_axis_tdata;
    logic                           m_axis_tlast;

    codec_scoreboard                sb;
    logic [ishc_pkg::FIELD_W-1:0]   payload [DATA_WORDS];
    logic [ishc_pkg::FIELD_W-1:0]   coded [ishc_pkg::WINDOW_WORDS];
    int                             words_sent;
    int                             sink_beats;
    int                             quiet_cycles;
    bit                             burst;

    interleaved_secded_hamming_codec dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [ishc_pkg::FIELD_W-1:0] pick_data();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return ishc_pkg::FIELD_W'($urandom);
    endfunction

    // Place data words at their positions and fill in every check position.
    function automatic void build_codeword();
        int k;
        k = 0;
        for (int p = 0; p < ishc_pkg::WINDOW_WORDS; p++) begin
            coded[p] = '0;
            if (!codec_scoreboard::is_check_pos(p)) begin
                coded[p] = payload[k];
                k++;
            end
        end
        for (int q = 1; q < ishc_pkg::WINDOW_WORDS; q = q * 2) begin
            for (int p = 0; p < ishc_pkg::WINDOW_WORDS; p++) begin
                if ((p & q) != 0 && p != q) coded[q] ^= coded[p];
            end
        end
        for (int p = 1; p < ishc_pkg::WINDOW_WORDS; p++) coded[0] ^= coded[p];
    endfunction

    function automatic void flip(int p, int c);
        coded[p][c] = ~coded[p][c];
    endfunction

    // Per column: mostly clean or single errors, some double, a few triple.
    function automatic void corrupt_columns();
        int r;
        int p1;
        int a;
        int b;
        for (int c = 0; c < ishc_pkg::COL_W; c++) begin
            r  = $urandom_range(0, 99);
            p1 = $urandom_range(0, ishc_pkg::WINDOW_WORDS - 1);
            a  = $urandom_range(1, 7);
            b  = $urandom_range(1, 7);
            if (r >= 45) flip(p1, c);
            if (r >= 80) flip((p1 + a) % ishc_pkg::WINDOW_WORDS, c);
            if (r >= 95) flip((p1 + a + b) % ishc_pkg::WINDOW_WORDS, c);
        end
    endfunction

    task automatic push_word(input logic [ishc_pkg::FIELD_W-1:0] w);
        int gap;
        gap = burst ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic send_data();
        for (int k = 0; k < DATA_WORDS; k++) push_word(payload[k]);
    endtask

    task automatic send_coded();
        for (int p = 0; p < ishc_pkg::WINDOW_WORDS; p++) push_word(coded[p]);
    endtask

    // Drop valid, drain every awaited beat, then let the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_mode(input ishc_pkg::t_mode m);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        sb.set_mode(m);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Beat monitor: feed accepted input to the predictor, check accepted output.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_word(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_beat(m_axis_tdata[ishc_pkg::FIELD_W-1:0], m_axis_tlast,
                          m_axis_tdata[2*ishc_pkg::FIELD_W-1:ishc_pkg::FIELD_W],
                          m_axis_tdata[3*ishc_pkg::FIELD_W-1:2*ishc_pkg::FIELD_W]);
            sink_beats++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Output side: random stalls, plus one long hold-off to back the block up.
    initial begin
        int  stall;
        bit  held_long;
        held_long = 0;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = idle_len();
            if (!held_long && sink_beats >= 40) begin
                held_long = 1;
                stall     = 300;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin
        int              phase;
        int              windows;
        int              partial;
        ishc_pkg::t_mode m;
        sb           = new();
        words_sent   = 0;
        sink_beats   = 0;
        quiet_cycles = 0;
        burst        = 0;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Encode from reset mode with extreme, single-bit and mixed data.
        payload = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0001, 16'h8000,
                    16'h0100, 16'hFFFE, 16'h7FFF, 16'h1234, 16'h0F0F};
        send_data();
        // Partial window, abandoned by the mode write.
        push_word(16'hFFFF);
        push_word(16'h0000);
        drain();
        write_mode(ishc_pkg::MODE_DECODE);

        // One window covering each decode case in its own column.
        build_codeword();
        flip(5, 0);                              // single data error
        flip(0, 1);                              // overall parity bit only
        flip(3, 2);  flip(9, 2);                 // double error
        flip(4, 3);                              // error in a check position
        flip(2, 4);  flip(0, 4);                 // double error touching position 0
        flip(0, 8);  flip(6, 8);  flip(10, 8);   // triple error, miscorrected
        flip(15, 15);                            // last position
        send_coded();
        drain();

        phase = 0;
        while (words_sent < TARGET_WORDS) begin
            m = (phase == 0) ? ishc_pkg::MODE_ENCODE :
                ($urandom_range(0, 1) ? ishc_pkg::MODE_DECODE : ishc_pkg::MODE_ENCODE);
            write_mode(m);
            // The first phase streams back to back so the long hold-off backs the block up.
            windows = (phase == 0) ? 4 : $urandom_range(1, 4);
            for (int w = 0; w < windows; w++) begin
                burst = (phase == 0) || ($urandom_range(0, 3) == 0);
                foreach (payload[k]) payload[k] = pick_data();
                if (m == ishc_pkg::MODE_ENCODE) begin
                    send_data();
                end else begin
                    build_codeword();
                    if ($urandom_range(0, 9) < 8) begin
                        corrupt_columns();
                    end else begin
                        foreach (coded[p]) coded[p] = ishc_pkg::FIELD_W'($urandom);
                    end
                    send_coded();
                end
            end
            burst = 0;
            if ($urandom_range(0, 3) == 0) begin
                partial = $urandom_range(1, (m == ishc_pkg::MODE_ENCODE) ?
                                            DATA_WORDS - 1 : ishc_pkg::WINDOW_WORDS - 1);
                repeat (partial) push_word(ishc_pkg::FIELD_W'($urandom));
            end
            drain();
            phase++;
        end

        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            if (sb.pending() != 0)
                $display("%0t: %0d awaited beats never arrived", $time, sb.pending());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: interleaved_secded_hamming_codec.f
hdl/ishc_pkg.sv
hdl/ishc_ram.sv
hdl/ishc_col_acc.sv
hdl/interleaved_secded_hamming_codec.sv
test/tb.sv
